[src/kuf_pkg.sv]
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared widths, codes and controller/datapath interface types for the
// union-find engine.
// ----------------------------------------------------------------------------
package kuf_pkg;

    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 32;
    localparam int RANK_W   = 4;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam logic [COST_W-1:0] COST_MAX = 32'hFFFF_FFFF;

    // table read address select
    typedef enum logic [1:0] {
        RS_NA = 2'd0,
        RS_NB = 2'd1,
        RS_UP = 2'd2
    } t_rsel;

    // table write operation
    typedef enum logic [2:0] {
        MOP_NONE     = 3'd0,
        MOP_CLEAR    = 3'd1,
        MOP_COMPRESS = 3'd2,
        MOP_LINK     = 3'd3,
        MOP_BUMP     = 3'd4
    } t_mop;

    typedef struct packed {
        logic  capture;
        logic  rd_en;
        t_rsel rsel;
        logic  root_a;
        logic  root_b;
        t_mop  mop;
        logic  add_cost;
        logic  clear_cost;
        logic  load_out;
        logic  clr_start;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic in_range;
        logic at_root;
        logic up_is_top;
        logic na_is_cur;
        logic nb_is_cur;
        logic same_root;
        logic rank_eq;
        logic clr_last;
    } t_sts;

endpackage

[src/kuf_dpath.sv]
// ----------------------------------------------------------------------------
// kuf_dpath
// Parent/rank table memory, walk registers, running cost and result
// registers of the union-find engine.
// ----------------------------------------------------------------------------
module kuf_dpath #(
    parameter int NODE_COUNT  = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_mode,
    input  logic [kuf_pkg::NODE_W-1:0]  i_node_a,
    input  logic [kuf_pkg::NODE_W-1:0]  i_node_b,
    input  logic [kuf_pkg::WEIGHT_W-1:0] i_weight,
    input  kuf_pkg::t_cmd               i_cmd,
    output kuf_pkg::t_sts               o_sts,
    output logic                        o_joined,
    output logic [kuf_pkg::COST_W-1:0]  o_total_cost
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int DW = AW + kuf_pkg::RANK_W;
    localparam logic [kuf_pkg::WEIGHT_W-1:0] W_MASK =
        (WEIGHT_BITS >= kuf_pkg::WEIGHT_W) ? {kuf_pkg::WEIGHT_W{1'b1}} :
        kuf_pkg::WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [AW-1:0] CLR_LAST = AW'(NODE_COUNT - 1);

    logic [DW-1:0]                  mem [NODE_COUNT];
    logic [DW-1:0]                  r_rdata;

    logic                           r_mode;
    logic [kuf_pkg::NODE_W-1:0]     r_na;
    logic [kuf_pkg::NODE_W-1:0]     r_nb;
    logic [kuf_pkg::WEIGHT_W-1:0]   r_w;
    logic [AW-1:0]                  r_cur;
    logic [AW-1:0]                  r_top;
    logic [AW-1:0]                  r_ra;
    logic [AW-1:0]                  r_rb;
    logic [kuf_pkg::RANK_W-1:0]     r_rka;
    logic [kuf_pkg::RANK_W-1:0]     r_rkb;
    logic [AW-1:0]                  r_clr;
    logic [kuf_pkg::COST_W-1:0]     r_cost;
    logic                           r_joined;
    logic                           r_out_joined;
    logic [kuf_pkg::COST_W-1:0]     r_out_total;

    logic [AW-1:0]                  rd_parent;
    logic [kuf_pkg::RANK_W-1:0]     rd_rank;
    logic [AW-1:0]                  raddr;
    logic                           we;
    logic [AW-1:0]                  waddr;
    logic [DW-1:0]                  wdata;
    logic                           rank_lt;
    logic [kuf_pkg::RANK_W-1:0]     rka_inc;
    logic [kuf_pkg::COST_W:0]       sum;
    logic [kuf_pkg::COST_W-1:0]     n_cost;

    assign rd_parent = r_rdata[AW-1:0];
    assign rd_rank   = r_rdata[DW-1:AW];
    assign rank_lt   = r_rka < r_rkb;
    assign rka_inc   = (r_rka == kuf_pkg::RANK_MAX) ? r_rka : r_rka + 1'b1;

    assign sum    = {1'b0, r_cost} + (kuf_pkg::COST_W+1)'(r_w & W_MASK);
    assign n_cost = sum[kuf_pkg::COST_W] ? kuf_pkg::COST_MAX : sum[kuf_pkg::COST_W-1:0];

    always_comb begin
        case (i_cmd.rsel)
            kuf_pkg::RS_NA: raddr = AW'(r_na);
            kuf_pkg::RS_NB: raddr = AW'(r_nb);
            default:        raddr = rd_parent;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = r_cur;
        wdata = {rd_rank, r_top};
        case (i_cmd.mop)
            kuf_pkg::MOP_CLEAR: begin
                waddr = r_clr;
                wdata = {kuf_pkg::RANK_W'(0), r_clr};
            end
            kuf_pkg::MOP_COMPRESS: begin
                waddr = r_cur;
                wdata = {rd_rank, r_top};
            end
            kuf_pkg::MOP_LINK: begin
                if (rank_lt) begin
                    waddr = r_ra;
                    wdata = {r_rka, r_rb};
                end else begin
                    waddr = r_rb;
                    wdata = {r_rkb, r_ra};
                end
            end
            kuf_pkg::MOP_BUMP: begin
                waddr = r_ra;
                wdata = {rka_inc, r_ra};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_na   <= i_node_a;
            r_nb   <= i_node_b;
            r_w    <= i_weight;
        end
        if (i_cmd.rd_en) begin
            r_cur <= raddr;
        end
        if (i_cmd.root_a) begin
            r_ra  <= r_cur;
            r_rka <= rd_rank;
            r_top <= r_cur;
        end
        if (i_cmd.root_b) begin
            r_rb  <= r_cur;
            r_rkb <= rd_rank;
            r_top <= r_cur;
        end
        if (i_cmd.capture) begin
            r_joined <= 1'b0;
        end else if (i_cmd.add_cost) begin
            r_joined <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_joined <= r_joined;
            r_out_total  <= r_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_cost <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr <= '0;
            end else if (i_cmd.mop == kuf_pkg::MOP_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.clear_cost) begin
                r_cost <= '0;
            end else if (i_cmd.add_cost) begin
                r_cost <= n_cost;
            end
        end
    end

    assign o_sts.restart   = r_mode;
    assign o_sts.in_range  = (32'(r_na) < NODE_COUNT) && (32'(r_nb) < NODE_COUNT);
    assign o_sts.at_root   = rd_parent == r_cur;
    assign o_sts.up_is_top = rd_parent == r_top;
    assign o_sts.na_is_cur = AW'(r_na) == r_cur;
    assign o_sts.nb_is_cur = AW'(r_nb) == r_cur;
    assign o_sts.same_root = r_ra == r_rb;
    assign o_sts.rank_eq   = r_rka == r_rkb;
    assign o_sts.clr_last  = r_clr == CLR_LAST;

    assign o_joined     = r_out_joined;
    assign o_total_cost = r_out_total;

endmodule

[src/kuf_ctrl.sv]
// ----------------------------------------------------------------------------
// kuf_ctrl
// Sequencer of the union-find engine: table clear, two root walks with
// path compression, union by rank and result hand-off.
// ----------------------------------------------------------------------------
module kuf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output kuf_pkg::t_cmd o_cmd,
    input  kuf_pkg::t_sts i_sts
);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_CHK   = 11'b000_0000_0100,
        S_FA    = 11'b000_0000_1000,
        S_CA    = 11'b000_0001_0000,
        S_SB    = 11'b000_0010_0000,
        S_FB    = 11'b000_0100_0000,
        S_CB    = 11'b000_1000_0000,
        S_UNION = 11'b001_0000_0000,
        S_BUMP  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.rsel    = kuf_pkg::RS_UP;
        o_cmd.mop     = kuf_pkg::MOP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.mop = kuf_pkg::MOP_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.restart) begin
                    o_cmd.clear_cost = 1'b1;
                    n_state          = S_DONE;
                end else if (!i_sts.in_range) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rsel  = kuf_pkg::RS_NA;
                    n_state     = S_FA;
                end
            end
            S_FA: begin
                if (i_sts.at_root) begin
                    o_cmd.root_a = 1'b1;
                    if (i_sts.na_is_cur) begin
                        n_state = S_SB;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rsel  = kuf_pkg::RS_NA;
                        n_state     = S_CA;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_CA: begin
                o_cmd.mop = kuf_pkg::MOP_COMPRESS;
                if (i_sts.up_is_top) begin
                    n_state = S_SB;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_SB: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rsel  = kuf_pkg::RS_NB;
                n_state     = S_FB;
            end
            S_FB: begin
                if (i_sts.at_root) begin
                    o_cmd.root_b = 1'b1;
                    if (i_sts.nb_is_cur) begin
                        n_state = S_UNION;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rsel  = kuf_pkg::RS_NB;
                        n_state     = S_CB;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_CB: begin
                o_cmd.mop = kuf_pkg::MOP_COMPRESS;
                if (i_sts.up_is_top) begin
                    n_state = S_UNION;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_UNION: begin
                if (i_sts.same_root) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mop      = kuf_pkg::MOP_LINK;
                    o_cmd.add_cost = 1'b1;
                    n_state        = i_sts.rank_eq ? S_BUMP : S_DONE;
                end
            end
            S_BUMP: begin
                o_cmd.mop = kuf_pkg::MOP_BUMP;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.restart) begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_out_valid;

endmodule

[src/kruskal_union_find_engine_unit.sv]
// ----------------------------------------------------------------------------
// kruskal_union_find_engine_unit
// Kruskal spanning-forest back end: union by rank with path compression over
// a parent/rank table, saturating running cost.
// ----------------------------------------------------------------------------
// Edge: each endpoint in turn is walked up its parent pointers to its root and
//   its path compressed; the roots are then linked by rank, bumping a rank on a tie.
// Restart and out-of-range edges skip the walks; a restart also zeroes the total
//   and then re-clears the table with o_ready low.
// Flow: one transaction in flight; the next is accepted after the result loads.
// Reset: synchronous; clears the total and sweeps every table entry.
// ----------------------------------------------------------------------------
module kruskal_union_find_engine_unit #(
    parameter int NODE_COUNT  = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [kuf_pkg::NODE_W-1:0]   i_node_a,
    input  logic [kuf_pkg::NODE_W-1:0]   i_node_b,
    input  logic [kuf_pkg::WEIGHT_W-1:0] i_weight,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_joined,
    output logic [kuf_pkg::COST_W-1:0]   o_total_cost
);

    kuf_pkg::t_cmd cmd;
    kuf_pkg::t_sts sts;

    kuf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    kuf_dpath #(
        .NODE_COUNT  (NODE_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_mode),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .i_weight     (i_weight),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_joined     (o_joined),
        .o_total_cost (o_total_cost)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("transaction accepted while previous one in flight");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (cmd.mop == kuf_pkg::MOP_NONE))
        else $error("table write while idle");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mop == kuf_pkg::MOP_CLEAR) |-> !o_ready)
        else $error("input ready during table clear");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_valid || i_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

[verif/tb_kruskal_union_find_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kruskal_union_find_engine_unit
// Self-checking bench for the union-find spanning-forest engine. A queue of
// edge and restart transactions feeds a clocked driver. A clocked monitor
// checks each result against a forest model with path compression and
// union by rank. Both sides throttle in three phases.
// ----------------------------------------------------------------------------
module tb_kruskal_union_find_engine_unit;

    localparam int    NODES     = 1024;
    localparam int    WBITS     = 16;
    localparam real   HALF_PER  = 6.0;
    localparam int    TAIL_CYC  = 64;
    localparam logic  MODE_EDGE = 1'b0;
    localparam logic  MODE_RST  = 1'b1;

    typedef struct {
        logic                         mode;
        logic [kuf_pkg::NODE_W-1:0]   na;
        logic [kuf_pkg::NODE_W-1:0]   nb;
        logic [kuf_pkg::WEIGHT_W-1:0] w;
        bit                           drain;
    } t_edge_item;

    typedef struct {
        logic                       joined;
        logic [kuf_pkg::COST_W-1:0] total;
    } t_tally;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_mode;
    logic [kuf_pkg::NODE_W-1:0]   i_node_a;
    logic [kuf_pkg::NODE_W-1:0]   i_node_b;
    logic [kuf_pkg::WEIGHT_W-1:0] i_weight;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_joined;
    logic [kuf_pkg::COST_W-1:0]   o_total_cost;

    t_edge_item edge_q[$];
    t_tally     tally_q[$];

    logic [kuf_pkg::NODE_W-1:0] parent_tab [NODES];
    logic [kuf_pkg::RANK_W-1:0] rank_tab   [NODES];
    logic [kuf_pkg::COST_W-1:0] cost_acc;

    int  n_total;
    int  n_acc;
    int  n_chk;
    int  n_err;
    int  n_join;
    int  n_rst;
    int  n_drain;
    bit  in_taken;

    kruskal_union_find_engine_unit #(
        .NODE_COUNT  (NODES),
        .WEIGHT_BITS (WBITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .i_weight     (i_weight),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_joined     (o_joined),
        .o_total_cost (o_total_cost)
    );

    initial i_clk = 1'b0;
    always #(HALF_PER) i_clk = ~i_clk;

    task automatic forest_clear();
        for (int k = 0; k < NODES; k++) begin
            parent_tab[k] = kuf_pkg::NODE_W'(k);
            rank_tab[k]   = '0;
        end
        cost_acc = '0;
    endtask

    function automatic logic [kuf_pkg::NODE_W-1:0] forest_find(
            input logic [kuf_pkg::NODE_W-1:0] node);
        logic [kuf_pkg::NODE_W-1:0] top;
        logic [kuf_pkg::NODE_W-1:0] cur;
        logic [kuf_pkg::NODE_W-1:0] up;
        int guard;
        top   = node;
        guard = 0;
        while (parent_tab[top] != top && guard < NODES) begin
            top = parent_tab[top];
            guard++;
        end
        cur   = node;
        guard = 0;
        while (cur != top && guard < NODES) begin
            up              = parent_tab[cur];
            parent_tab[cur] = top;
            cur             = up;
            guard++;
        end
        return top;
    endfunction

    task automatic forest_apply(input logic mode, input logic [kuf_pkg::NODE_W-1:0] na,
                                input logic [kuf_pkg::NODE_W-1:0] nb,
                                input logic [kuf_pkg::WEIGHT_W-1:0] w);
        logic [kuf_pkg::NODE_W-1:0] ra;
        logic [kuf_pkg::NODE_W-1:0] rb;
        logic [kuf_pkg::COST_W:0]   sum;
        t_tally                     t;
        t.joined = 1'b0;
        if (mode == MODE_RST) begin
            forest_clear();
            n_rst++;
        end else begin
            ra = forest_find(na);
            rb = forest_find(nb);
            if (ra != rb) begin
                if (rank_tab[ra] < rank_tab[rb]) begin
                    parent_tab[ra] = rb;
                end else if (rank_tab[ra] > rank_tab[rb]) begin
                    parent_tab[rb] = ra;
                end else begin
                    parent_tab[rb] = ra;
                    if (rank_tab[ra] < kuf_pkg::RANK_MAX) rank_tab[ra] = rank_tab[ra] + 1'b1;
                end
                sum = {1'b0, cost_acc} + (kuf_pkg::COST_W + 1)'(w);
                cost_acc = (sum > {1'b0, kuf_pkg::COST_MAX}) ? kuf_pkg::COST_MAX
                                                             : sum[kuf_pkg::COST_W-1:0];
                t.joined = 1'b1;
                n_join++;
            end
        end
        t.total = cost_acc;
        tally_q.push_back(t);
    endtask

    // idle percentages: phase 0 sender 23 / receiver 68, phase 1 swapped, phase 2 none
    function automatic int src_idle_pct();
        int ph;
        ph = (n_total == 0) ? 2 : (n_acc * 3) / n_total;
        return (ph == 0) ? 23 : (ph == 1) ? 68 : 0;
    endfunction

    function automatic int snk_idle_pct();
        int ph;
        ph = (n_total == 0) ? 2 : (n_acc * 3) / n_total;
        return (ph == 0) ? 68 : (ph == 1) ? 23 : 0;
    endfunction

    task automatic push_edge(input logic mode, input int na, input int nb,
                             input int w, input bit drain);
        t_edge_item e;
        e.mode  = mode;
        e.na    = kuf_pkg::NODE_W'(na);
        e.nb    = kuf_pkg::NODE_W'(nb);
        e.w     = kuf_pkg::WEIGHT_W'(w);
        e.drain = drain;
        edge_q.push_back(e);
    endtask

    task automatic build_stimulus();
        int pool;
        int base;
        int seg_len;
        int w;
        int a;
        int b;
        int seg;
        // directed
        push_edge(MODE_RST, 0, 0, 0, 1'b0);
        push_edge(MODE_EDGE, 5, 5, 7, 1'b0);
        push_edge(MODE_EDGE, 0, 1023, 0, 1'b0);
        push_edge(MODE_EDGE, 1023, 0, 0, 1'b0);
        push_edge(MODE_EDGE, 1, 2, 1, 1'b0);
        push_edge(MODE_EDGE, 3, 1, 2, 1'b0);
        push_edge(MODE_EDGE, 0, 3, 3, 1'b0);
        push_edge(MODE_EDGE, 4, 0, 4, 1'b0);
        push_edge(MODE_EDGE, 2, 1023, 5, 1'b0);
        push_edge(MODE_EDGE, 6, 7, 6, 1'b0);
        push_edge(MODE_EDGE, 8, 9, 6, 1'b0);
        push_edge(MODE_EDGE, 6, 8, 9, 1'b0);
        push_edge(MODE_EDGE, 9, 4, 100, 1'b1);
        push_edge(MODE_EDGE, 7, 2, 100, 1'b0);
        push_edge(MODE_EDGE, 10, 11, 65535, 1'b0);
        push_edge(MODE_EDGE, 12, 13, 65535, 1'b0);
        push_edge(MODE_EDGE, 11, 13, 65535, 1'b0);
        push_edge(MODE_EDGE, 13, 10, 65535, 1'b0);
        push_edge(MODE_RST, 1023, 1023, 65535, 1'b1);
        push_edge(MODE_EDGE, 1023, 512, 32768, 1'b0);
        push_edge(MODE_EDGE, 682, 341, 43690, 1'b0);
        push_edge(MODE_EDGE, 512, 341, 65535, 1'b0);
        push_edge(MODE_EDGE, 1023, 682, 65535, 1'b0);
        // random forests: mostly a restart then sorted edges over a small node pool
        seg = 0;
        while (edge_q.size() < 1250) begin
            if ($urandom_range(99) < 90)
                push_edge(MODE_RST, $urandom_range(1023), $urandom_range(1023),
                          $urandom_range(65535), (seg % 9) == 4);
            pool    = $urandom_range(64, 4);
            base    = $urandom_range(NODES - pool, 0);
            seg_len = $urandom_range(60, 10);
            w       = ($urandom_range(3) == 0) ? $urandom_range(65535, 60000)
                                               : $urandom_range(2000);
            for (int k = 0; k < seg_len; k++) begin
                if ($urandom_range(99) < 5) begin
                    push_edge(MODE_EDGE, $urandom_range(1023), $urandom_range(1023),
                              $urandom_range(65535), 1'b0);
                end else begin
                    a = base + $urandom_range(pool - 1);
                    b = base + $urandom_range(pool - 1);
                    w = w + $urandom_range(300);
                    if (w > 65535) w = 65535;
                    push_edge(MODE_EDGE, a, b, w, 1'b0);
                end
            end
            seg++;
        end
        n_total = edge_q.size();
    endtask

    // driver
    always @(negedge i_clk) begin
        t_edge_item e;
        logic       nv;
        if (i_rst_n) begin
            nv = i_valid && !in_taken;
            if (!nv && edge_q.size() != 0 &&
                !(edge_q[0].drain && tally_q.size() != 0) &&
                $urandom_range(99) >= src_idle_pct()) begin
                e = edge_q.pop_front();
                if (e.drain) n_drain++;
                nv = 1'b1;
                i_mode   <= e.mode;
                i_node_a <= e.na;
                i_node_b <= e.nb;
                i_weight <= e.w;
            end
            i_valid  <= nv;
            i_ready  <= ($urandom_range(99) >= snk_idle_pct());
            in_taken = 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_tally t;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_chk++;
                if (tally_q.size() == 0) begin
                    $display("%0t: unexpected result joined=%0b total=%0d",
                             $time, o_joined, o_total_cost);
                    n_err++;
                end else begin
                    t = tally_q.pop_front();
                    if (o_joined !== t.joined) begin
                        $display("%0t: joined mismatch exp=%0b act=%0b",
                                 $time, t.joined, o_joined);
                        n_err++;
                    end
                    if (o_total_cost !== t.total) begin
                        $display("%0t: total_cost mismatch exp=%0d act=%0d",
                                 $time, t.total, o_total_cost);
                        n_err++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                forest_apply(i_mode, i_node_a, i_node_b, i_weight);
                n_acc++;
                in_taken = 1'b1;
            end
        end
    end

    initial begin
        #(12ms);
        $display("timeout after %0d of %0d transactions", n_acc, n_total);
        $display("simulation failed");
        $finish;
    end

    initial begin
        n_total  = 0;
        n_acc    = 0;
        n_chk    = 0;
        n_err    = 0;
        n_join   = 0;
        n_rst    = 0;
        n_drain  = 0;
        in_taken = 1'b0;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_ready  = 1'b0;
        i_mode   = 1'b0;
        i_node_a = '0;
        i_node_b = '0;
        i_weight = '0;
        forest_clear();
        build_stimulus();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (edge_q.size() != 0 || i_valid) @(posedge i_clk);
        while (tally_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (tally_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, tally_q.size());
            n_err++;
        end
        $display("covered %0d transactions: %0d restarts, %0d joining edges, %0d drain holds",
                 n_acc, n_rst, n_join, n_drain);
        $display("checked %0d results, %0d mismatches", n_chk, n_err);
        if (n_err == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
